@@ hw/rtl/sc2a_pkg.sv @@
`timescale 1ns / 1ps

package sc2a_pkg;

  localparam int FIFO_DEPTH_DEF = 256;
  localparam int CHAR_W         = 7;
  localparam int CODE_W         = 8;
  localparam int LEVEL_W        = 9;

  // transaction commands
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // set-1 modifier keys, release bit stripped
  localparam logic [CHAR_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [CHAR_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [CHAR_W-1:0] KEY_CAPS   = 7'h3A;
  localparam logic [CHAR_W-1:0] KEY_CTRL   = 7'h1D;
  localparam logic [CHAR_W-1:0] KEY_ALT    = 7'h38;

  localparam logic [CHAR_W-1:0] ASCII_LOWER_R = 7'h72;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_R = 7'h52;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 7'h7A;

  localparam int MAP_N = 64;

  // us layout, unshifted
  localparam logic [CHAR_W-1:0] PLAIN_MAP [MAP_N] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // us layout, shifted
  localparam logic [CHAR_W-1:0] UPPER_MAP [MAP_N] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

@@ hw/rtl/sc2a_ram.sv @@
`timescale 1ns / 1ps

module sc2a_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/scancode_to_ascii_with_fifo.sv @@
`timescale 1ns / 1ps

// PS/2 set-1 scancode decoder with a character queue. Every cycle one transaction is
// taken: a scancode (command 0) updates shift/ctrl/caps state and, for a printable make
// code, pushes its US-layout character into a FIFO_DEPTH-entry queue unless full, or
// flags a snapshot request for ctrl+r; a read (command 1) pops one character if any.
// Each transaction's result is registered for the next cycle, so the throughput is one
// transaction per cycle while out_ready is high. The queue sits in a single RAM with one
// write and one registered read per cycle; a push and a pop never share a cycle, so no
// forwarding is needed, and the RAM is not cleared after reset since only written
// entries are ever popped. fifo_level reports the low 9 bits of the fill count.
module scancode_to_ascii_with_fifo
  import sc2a_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [CODE_W-1:0]  in_scancode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_decoded_char,
  output logic               out_snapshot_request,
  output logic [CHAR_W-1:0]  out_read_char,
  output logic [LEVEL_W-1:0] out_fifo_level
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  logic              lshift_r, lshift_nxt;
  logic              rshift_r, rshift_nxt;
  logic              caps_r, caps_nxt;
  logic              ctrl_r, ctrl_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_snap_r;
  logic              out_pop_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              in_fire;
  logic              is_scan;
  logic              pressed;
  logic [CHAR_W-1:0] key;
  logic              is_modifier;
  logic [CHAR_W-1:0] lo_char;
  logic [CHAR_W-1:0] hi_char;
  logic              letter;
  logic [CHAR_W-1:0] ch;
  logic              snap;
  logic              push;
  logic              pop;
  logic [CHAR_W-1:0] ram_rdata;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_scan  = (in_command == CMD_SCAN);
  assign pressed  = !in_scancode[CODE_W-1];
  assign key      = in_scancode[CHAR_W-1:0];
  assign lo_char  = PLAIN_MAP[key[5:0]];
  assign hi_char  = UPPER_MAP[key[5:0]];
  assign letter   = lo_char inside {[ASCII_LOWER_A:ASCII_LOWER_Z]};

  // alt is swallowed like the other modifiers; it changes no character
  assign is_modifier = (key == KEY_LSHIFT) || (key == KEY_RSHIFT) || (key == KEY_CAPS) ||
                       (key == KEY_CTRL) || (key == KEY_ALT);

  always_comb begin
    ch = '0;
    if (is_scan && !is_modifier && pressed && !key[CHAR_W-1] && lo_char != '0) begin
      if (lshift_r || rshift_r) begin
        ch = (caps_r && letter) ? lo_char : hi_char;
      end else begin
        ch = (caps_r && letter) ? hi_char : lo_char;
      end
    end
  end

  assign snap = ctrl_r && (ch == ASCII_LOWER_R || ch == ASCII_UPPER_R);
  assign push = in_fire && is_scan && ch != '0 && !snap && cnt_r < CNT_FULL;
  assign pop  = in_fire && !is_scan && cnt_r != '0;

  always_comb begin
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    caps_nxt   = caps_r;
    ctrl_nxt   = ctrl_r;
    if (in_fire && is_scan) begin
      case (key)
        KEY_LSHIFT: lshift_nxt = pressed;
        KEY_RSHIFT: rshift_nxt = pressed;
        KEY_CAPS:   caps_nxt   = caps_r ^ pressed;
        KEY_CTRL:   ctrl_nxt   = pressed;
        default:    ;
      endcase
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      cnt_nxt    = cnt_r + CNT_W'(1);
    end else if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      cnt_nxt    = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lshift_r    <= 1'b0;
      rshift_r    <= 1'b0;
      caps_r      <= 1'b0;
      ctrl_r      <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      caps_r   <= caps_nxt;
      ctrl_r   <= ctrl_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_char_r <= ch;
      out_snap_r <= snap;
      out_pop_r  <= pop;
      out_cnt_r  <= cnt_nxt;
    end
  end

  // read data is only reloaded on a new transaction, so it holds while the result stalls
  sc2a_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (FIFO_DEPTH),
    .ADDR_W(PTR_W)
  ) u_store (
    .clk  (clk),
    .we   (push),
    .waddr(wr_ptr_r),
    .wdata(ch),
    .re   (pop),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  assign out_valid            = out_valid_r;
  assign out_decoded_char     = out_char_r;
  assign out_snapshot_request = out_snap_r;
  assign out_read_char        = out_pop_r ? ram_rdata : '0;
  assign out_fifo_level       = LEVEL_W'(out_cnt_r);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CNT_FULL) |-> wr_ptr_r == rd_ptr_r)
    else $error("pointers disagree with fill count");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_scan && cnt_r != '0) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("pop did not decrement fill count");

  a_snap_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_snap_r && out_pop_r))
    else $error("snapshot and pop in one result");
`endif

endmodule
